@@ src/aerm_pkg.sv @@
`default_nettype none

package aerm_pkg;

	// Field widths.
	localparam int CMD_W    = 2;
	localparam int INC_W    = 16;
	localparam int TIME_W   = 48;
	localparam int CNT_W    = 32;
	localparam int IVL_W    = 26;
	localparam int STEP_W   = 10;
	localparam int US_W     = 20;

	// Stream payload widths, the sum of their fields; both come to whole bytes.
	localparam int IN_DATA_W  = INC_W + TIME_W;
	localparam int OUT_DATA_W = CNT_W + CNT_W + TIME_W;

	// Datapath widths of the shared multiplier and divider.
	localparam int PROD_W     = CNT_W + IVL_W;
	localparam int RATE_NUM_W = CNT_W + US_W;
	localparam int DIV_W      = TIME_W + 4;
	localparam int REM_W      = DIV_W + 1;
	localparam int RATE_QB    = 32;
	localparam int CHECK_QB   = STEP_W;
	localparam int BITCNT_W   = $clog2(RATE_QB);

	localparam logic [IVL_W-1:0] US_PER_SEC     = IVL_W'(1000000);
	localparam logic [IVL_W-1:0] INTERVAL_RESET = IVL_W'(1000000);

	// Command codes carried in the input tuser.
	localparam logic [CMD_W-1:0] CMD_COUNT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

	// Register indexes on the configuration port.
	localparam logic REG_INTERVAL = 1'b0;
	localparam logic REG_RUN      = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL_A,
		ST_CHK_A,
		ST_DIV_A,
		ST_MUL_B,
		ST_CHK_B,
		ST_DIV_B,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

@@ src/adaptive_event_rate_meter.sv @@
// A count item that leaves the total below the mark, a start or stop command, or a time
// check that finds the interval not yet elapsed has its result loaded from the evaluation
// state; a rate update forms two 32x26 products and runs two bit-serial restoring divisions,
// to 32 and to 10 quotient bits, each skipped when its quotient saturates. Flow: one item at
// a time; the next is accepted the cycle after a result is loaded, and output stalls hold it.
// Reset (arst_n low, asynchronous): all counters, marks and the rate clear, the check step is 1.
`default_nettype none

module adaptive_event_rate_meter #(
	parameter int MAX_CHECK_STEP = 1000
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [aerm_pkg::IN_DATA_W-1:0]      s_tdata,   // increment [15:0], now_us [63:16]
	input  logic [aerm_pkg::CMD_W-1:0]          s_tuser,   // cmd [1:0]

	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [aerm_pkg::OUT_DATA_W-1:0]     m_tdata,   // rate_per_sec [31:0],
	                                                       // event_total [63:32],
	                                                       // run_time_us [111:64]
	output logic [0:0]                          m_tuser,   // updated [0]

	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	import aerm_pkg::*;

	localparam logic [STEP_W-1:0] MAX_STEP = STEP_W'(MAX_CHECK_STEP);

	// Control and architectural state.
	state_t              state_q, state_d;
	logic [IVL_W-1:0]    interval_q;
	logic                run_en_q;
	logic [CNT_W-1:0]    total_q;
	logic [CNT_W-1:0]    cnt_upd_q;
	logic [TIME_W-1:0]   time_upd_q;
	logic [CNT_W-1:0]    mark_q;
	logic [STEP_W-1:0]   step_q;
	logic [CNT_W-1:0]    rate_q;
	logic [TIME_W-1:0]   run_q;
	logic [BITCNT_W-1:0] bit_cnt_q;
	logic                sat_q;
	logic                out_valid_q;

	// Item and datapath registers.
	logic [CMD_W-1:0]    cmd_q;
	logic                inc_zero_q;
	logic [TIME_W-1:0]   now_q;
	logic [CNT_W-1:0]    delta_q;
	logic [TIME_W-1:0]   elapsed_q;
	logic [PROD_W-1:0]   num_q;
	logic [DIV_W-1:0]    div_q;
	logic [REM_W-1:0]    rem_q;
	logic [RATE_QB-1:0]  lo_q;
	logic [RATE_QB-1:0]  quo_q;
	logic                out_upd_q;
	logic [CNT_W-1:0]    out_rate_q;
	logic [CNT_W-1:0]    out_total_q;
	logic [TIME_W-1:0]   out_run_q;

	// Combinational signals.
	logic                accept;
	logic                cfg_wr;
	logic                out_free;
	logic                ld_out;
	logic                out_upd_d;
	logic [CNT_W-1:0]    out_rate_d;
	logic [TIME_W-1:0]   out_run_d;
	logic [IVL_W-1:0]    ivl_eff;
	logic [TIME_W-1:0]   elapsed_raw;
	logic                elapsed_ok;
	logic                below_mark;
	logic                forced;
	logic [CNT_W-1:0]    forced_rate;
	logic [IVL_W-1:0]    mul_b;
	logic [PROD_W-1:0]   prod;
	logic                sat_a;
	logic                sat_b;
	logic [REM_W-1:0]    rem_sh;
	logic                rem_ge;
	logic [REM_W-1:0]    rem_nx;
	logic                div_a_done;
	logic                div_b_done;
	logic [STEP_W-1:0]   q_chk;
	logic [STEP_W-1:0]   step_new;

	// -------------------------------------------------------------------------------
	// Configuration port. Writes complete in the access phase; pready is tied high.
	// Only paddr[2] selects a register, so the two registers sit at byte 0 and byte 4.
	// -------------------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		case (paddr[2])
			REG_INTERVAL: prdata = {{(32-IVL_W){1'b0}}, interval_q};
			REG_RUN:      prdata = {31'b0, run_en_q};
			default:      prdata = '0;
		endcase
	end

	// -------------------------------------------------------------------------------
	// Item decode. The effective interval is never zero, so a rate update always
	// divides by at least one microsecond. A timestamp earlier than the last update
	// counts as not yet elapsed.
	// -------------------------------------------------------------------------------
	assign accept      = s_tvalid & s_tready;
	assign out_free    = ~out_valid_q | m_tready;
	assign ivl_eff     = (interval_q == '0) ? IVL_W'(1) : interval_q;
	assign elapsed_raw = now_q - time_upd_q;
	assign elapsed_ok  = (now_q >= time_upd_q) &&
	                     (elapsed_raw >= {{(TIME_W-IVL_W){1'b0}}, ivl_eff});
	assign below_mark  = ~inc_zero_q && (total_q < mark_q);
	assign forced      = (cmd_q != CMD_COUNT);
	// A start marker reports a rate of one; stop and the unused code report zero.
	assign forced_rate = (cmd_q == CMD_START) ? CNT_W'(1) : '0;

	// -------------------------------------------------------------------------------
	// Shared 32x26 multiplier. The first pass forms delta * 10^6 for the rate, the
	// second delta * interval for the check step. Its output is always registered.
	// -------------------------------------------------------------------------------
	assign mul_b = (state_q == ST_MUL_A) ? US_PER_SEC : ivl_eff;
	assign prod  = {{IVL_W{1'b0}}, delta_q} * {{CNT_W{1'b0}}, mul_b};

	// Saturation checks: the quotient overflows its field when the top part of the
	// numerator is already at least the divisor.
	assign sat_a = {{(TIME_W-(RATE_NUM_W-RATE_QB)){1'b0}}, num_q[RATE_NUM_W-1:RATE_QB]}
	               >= elapsed_q;
	assign sat_b = {{(DIV_W-(PROD_W-CHECK_QB)){1'b0}}, num_q[PROD_W-1:CHECK_QB]} >= div_q;

	// -------------------------------------------------------------------------------
	// Bit-serial restoring divider. Each cycle the remainder takes the next numerator
	// bit from the lo_q shift register and one quotient bit enters quo_q. The
	// remainder stays below the divisor between steps, so one extra bit is enough.
	// -------------------------------------------------------------------------------
	assign rem_sh     = {rem_q[REM_W-2:0], lo_q[RATE_QB-1]};
	assign rem_ge     = rem_sh >= {1'b0, div_q};
	assign rem_nx     = rem_ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
	assign div_a_done = (bit_cnt_q == BITCNT_W'(RATE_QB - 1));
	assign div_b_done = (bit_cnt_q == BITCNT_W'(CHECK_QB - 1));

	// Check step: a tenth of the expected counts per interval, kept within 1..MAX.
	assign q_chk = quo_q[STEP_W-1:0];
	always_comb begin
		if (sat_q || q_chk > MAX_STEP) begin
			step_new = MAX_STEP;
		end else if (q_chk < STEP_W'(2)) begin
			step_new = STEP_W'(1);
		end else begin
			step_new = q_chk;
		end
	end

	// -------------------------------------------------------------------------------
	// Sequencer: next state and result load.
	// -------------------------------------------------------------------------------
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		ld_out     = 1'b0;
		out_upd_d  = 1'b0;
		out_rate_d = rate_q;
		out_run_d  = run_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (forced) begin
					out_upd_d  = 1'b1;
					out_rate_d = forced_rate;
					ld_out     = out_free;
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else if (below_mark || !elapsed_ok) begin
					ld_out = out_free;
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				state_d = ST_CHK_A;
			end
			ST_CHK_A: begin
				state_d = sat_a ? ST_MUL_B : ST_DIV_A;
			end
			ST_DIV_A: begin
				if (div_a_done) begin
					state_d = ST_MUL_B;
				end
			end
			ST_MUL_B: begin
				state_d = ST_CHK_B;
			end
			ST_CHK_B: begin
				state_d = sat_b ? ST_FIN : ST_DIV_B;
			end
			ST_DIV_B: begin
				if (div_b_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				out_upd_d = 1'b1;
				out_run_d = run_en_q ? (run_q + elapsed_q) : run_q;
				ld_out    = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// -------------------------------------------------------------------------------
	// Architectural state: registers, totals, marks, rate and running time.
	// -------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
			run_en_q   <= 1'b0;
			total_q    <= '0;
			cnt_upd_q  <= '0;
			time_upd_q <= '0;
			mark_q     <= '0;
			step_q     <= STEP_W'(1);
			rate_q     <= '0;
			run_q      <= '0;
			bit_cnt_q  <= '0;
			sat_q      <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					REG_INTERVAL: interval_q <= pwdata[IVL_W-1:0];
					REG_RUN:      run_en_q   <= pwdata[0];
					default:      ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					// The total takes the increment at acceptance, so later cycles
					// of the same item may re-evaluate without adding twice.
					if (accept && s_tuser == CMD_COUNT) begin
						total_q <= total_q + {{(CNT_W-INC_W){1'b0}}, s_tdata[INC_W-1:0]};
					end
				end
				ST_EVAL: begin
					if (ld_out) begin
						if (forced) begin
							rate_q <= forced_rate;
						end else if (!below_mark) begin
							mark_q <= total_q + {{(CNT_W-STEP_W){1'b0}}, step_q};
						end
					end
				end
				ST_CHK_A: begin
					sat_q     <= sat_a;
					bit_cnt_q <= '0;
				end
				ST_DIV_A, ST_DIV_B: begin
					bit_cnt_q <= bit_cnt_q + BITCNT_W'(1);
				end
				ST_MUL_B: begin
					rate_q <= sat_q ? '1 : quo_q;
				end
				ST_CHK_B: begin
					sat_q     <= sat_b;
					bit_cnt_q <= '0;
				end
				ST_FIN: begin
					if (ld_out) begin
						run_q      <= out_run_d;
						time_upd_q <= now_q;
						cnt_upd_q  <= total_q;
						step_q     <= step_new;
						mark_q     <= total_q + {{(CNT_W-STEP_W){1'b0}}, step_new};
					end
				end
				default: ;
			endcase
		end
	end

	// -------------------------------------------------------------------------------
	// Item and divider datapath.
	// -------------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q      <= s_tuser;
					inc_zero_q <= (s_tdata[INC_W-1:0] == '0);
					now_q      <= s_tdata[IN_DATA_W-1:INC_W];
				end
			end
			ST_EVAL: begin
				delta_q   <= total_q - cnt_upd_q;
				elapsed_q <= elapsed_raw;
			end
			ST_MUL_A: begin
				num_q <= prod;
			end
			ST_CHK_A: begin
				rem_q <= {{(REM_W-(RATE_NUM_W-RATE_QB)){1'b0}},
				          num_q[RATE_NUM_W-1:RATE_QB]};
				lo_q  <= num_q[RATE_QB-1:0];
				div_q <= {{(DIV_W-TIME_W){1'b0}}, elapsed_q};
			end
			ST_DIV_A, ST_DIV_B: begin
				rem_q <= rem_nx;
				lo_q  <= {lo_q[RATE_QB-2:0], 1'b0};
				quo_q <= {quo_q[RATE_QB-2:0], rem_ge};
			end
			ST_MUL_B: begin
				num_q <= prod;
				// Ten times the elapsed time, as 8x plus 2x.
				div_q <= {1'b0, elapsed_q, 3'b000} + {3'b000, elapsed_q, 1'b0};
			end
			ST_CHK_B: begin
				rem_q <= {{(REM_W-(PROD_W-CHECK_QB)){1'b0}}, num_q[PROD_W-1:CHECK_QB]};
				lo_q  <= {num_q[CHECK_QB-1:0], {(RATE_QB-CHECK_QB){1'b0}}};
			end
			default: ;
		endcase
	end

	// -------------------------------------------------------------------------------
	// Result register. It frees the input side as soon as a result is loaded.
	// -------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_upd_q   <= out_upd_d;
			out_rate_q  <= out_rate_d;
			out_total_q <= total_q;
			out_run_q   <= out_run_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_run_q, out_total_q, out_rate_q};
	assign m_tuser  = out_upd_q;

`ifndef NO_ASSERTIONS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != '0 && step_q <= MAX_STEP)
		else $error("check step left its range");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_A || state_q == ST_DIV_B) |-> rem_q < {1'b0, div_q})
		else $error("divider remainder not below divisor");

	a_no_update_keeps_base: assert property (@(posedge clk) disable iff (!arst_n)
		(ld_out && !out_upd_d) |=> ($stable(time_upd_q) && $stable(cnt_upd_q)
		                            && $stable(rate_q)))
		else $error("result without update changed the update base");

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EVAL))
		else $error("accepted item not evaluated");
`endif

endmodule

`default_nettype wire
